// ----- design/gawsa_pkg.sv -----
// ----------------------------------------------------------------------------
// gawsa_pkg
// Shared constants, operation codes and types for the Gram and weighted-sum
// accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gawsa_pkg;

  // default vector length
  localparam int LatentDimDef = 16;

  // field widths
  localparam int ElemW = 16;
  localparam int ProdW = 2 * ElemW;
  localparam int AccW  = 48;
  localparam int IdxW  = 4;

  // operation codes carried in tuser
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // result of the shared multiply-accumulate unit
  typedef struct packed {
    logic signed [AccW-1:0] sum;
    logic                   sat;
  } mac_res_t;

  // start of row r in a row-major lower triangle: r*(r+1)/2
  function automatic logic [6:0] tri_base(input logic [IdxW-1:0] r);
    logic [8:0] p;
    p = 9'(r) * (9'(r) + 9'd1);
    return p[7:1];
  endfunction

endpackage

`default_nettype wire

// ----- design/gawsa_ram.sv -----
// ----------------------------------------------------------------------------
// gawsa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gawsa_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/gawsa_mac.sv -----
// ----------------------------------------------------------------------------
// gawsa_mac
// Shared 16x16 multiplier with a product register, followed by a 48-bit
// saturating add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gawsa_mac
  import gawsa_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    mul_en_i,
  input  wire logic signed [ElemW-1:0] a_i,
  input  wire logic signed [ElemW-1:0] b_i,
  input  wire logic signed [AccW-1:0]  acc_i,
  output mac_res_t                     res_o
);

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW:0]    ext_sum;

  // product register
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  // one guard bit catches overflow of the accumulator range
  assign ext_sum = {acc_i[AccW-1], acc_i} + (AccW+1)'(prod_q);

  always_comb begin
    res_o.sat = ext_sum[AccW] ^ ext_sum[AccW-1];
    if (!res_o.sat) begin
      res_o.sum = ext_sum[AccW-1:0];
    end else if (ext_sum[AccW]) begin
      res_o.sum = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      res_o.sum = {1'b0, {(AccW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ----- design/gram_and_weighted_sum_accumulator.sv -----
// ----------------------------------------------------------------------------
// gram_and_weighted_sum_accumulator
// Buffers a latent vector and, on its last element, adds rating*v to the
// weighted-sum vector and v*v' to the lower triangle of a Gram matrix.
// ----------------------------------------------------------------------------
// Sequence: a push without last mark leaves the block idle; a read passes ST_RADDR
// and ST_RDATA before tvalid rises; a push with last mark runs the whole
// accumulation, all multiply-accumulates run through one multiplier and one adder.
// Throughput: one item at a time; tready is high only while idle.
// Reset and clear: a pass over all K*(K+1)/2 Gram entries zeroes the accumulator
// RAMs; no input is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module gram_and_weighted_sum_accumulator
  import gawsa_pkg::*;
#(
  parameter int LATENT_DIM = LatentDimDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // elem, rating, read_row, read_col
  input  wire logic [2:0]  s_axis_tuser_i,   // op, read_vector
  input  wire logic        s_axis_tlast_i,   // last_elem
  // master side
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // acc_value
  output logic             m_axis_tuser_o    // overflow
);

  localparam int GramDepth = LATENT_DIM * (LATENT_DIM + 1) / 2;
  localparam int BufAw     = $clog2(LATENT_DIM);
  localparam int GramAw    = $clog2(GramDepth);
  localparam int CntW      = $clog2(LATENT_DIM + 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_ROW   = 4'd2;
  localparam logic [3:0] ST_VI    = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_WR    = 4'd6;
  localparam logic [3:0] ST_RADDR = 4'd7;
  localparam logic [3:0] ST_RDATA = 4'd8;

  // input fields
  logic [1:0]              in_op;
  logic signed [ElemW-1:0] in_elem;
  logic signed [ElemW-1:0] in_rating;
  logic [IdxW-1:0]         in_row;
  logic [IdxW-1:0]         in_col;
  logic                    in_vec;
  logic                    s_xfer;

  assign in_op     = s_axis_tuser_i[1:0];
  assign in_vec    = s_axis_tuser_i[2];
  assign in_elem   = s_axis_tdata_i[15:0];
  assign in_rating = s_axis_tdata_i[31:16];
  assign in_row    = s_axis_tdata_i[35:32];
  assign in_col    = s_axis_tdata_i[39:36];

  logic [3:0]              state_q, state_d;
  logic [BufAw-1:0]        i_q, i_d;
  logic [BufAw-1:0]        j_q, j_d;
  logic [GramAw-1:0]       gaddr_q, gaddr_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    ws_ph_q, ws_ph_d;
  logic                    ovf_q, ovf_d;
  logic signed [ElemW-1:0] vi_q, vi_d;
  logic signed [ElemW-1:0] rating_q;
  logic [IdxW-1:0]         rd_row_q, rd_col_q;
  logic                    rd_vec_q;
  logic                    rd_zero_q;
  logic                    m_valid_q;
  logic [AccW-1:0]         m_data_q;
  logic                    m_user_q;

  // memory ports
  logic                    buf_we, buf_re;
  logic [BufAw-1:0]        buf_waddr, buf_raddr;
  logic [ElemW-1:0]        buf_rdata;
  logic                    ws_we, ws_re;
  logic [BufAw-1:0]        ws_waddr, ws_raddr;
  logic [AccW-1:0]         ws_wdata, ws_rdata;
  logic                    gr_we, gr_re;
  logic [GramAw-1:0]       gr_raddr;
  logic [AccW-1:0]         gr_wdata, gr_rdata;

  // shared unit
  logic signed [ElemW-1:0] mac_b;
  logic signed [AccW-1:0]  mac_acc;
  mac_res_t                mac_res;

  // read addressing
  logic [IdxW-1:0]         rd_r, rd_c;
  logic [7:0]              rd_gidx;
  logic                    rd_in_range;
  logic                    out_load;
  logic                    row_done, acc_done;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_xfer          = s_axis_tvalid_i & s_axis_tready_o;

  // mirror upper-triangle reads onto the lower triangle
  always_comb begin
    if (!rd_vec_q && (rd_col_q > rd_row_q)) begin
      rd_r = rd_col_q;
      rd_c = rd_row_q;
    end else begin
      rd_r = rd_row_q;
      rd_c = rd_col_q;
    end
    rd_gidx     = {1'b0, tri_base(rd_r)} + {4'b0, rd_c};
    rd_in_range = (32'(rd_r) < 32'(LATENT_DIM));
  end

  assign row_done = (j_q == i_q);
  assign acc_done = row_done && (i_q == BufAw'(LATENT_DIM - 1));
  assign out_load = (state_q == ST_RDATA) && (!m_valid_q || m_axis_tready_i);

  // operand selection for the shared unit, unpushed elements count as zero
  always_comb begin
    if (ws_ph_q) begin
      mac_b = rating_q;
    end else if (CntW'(j_q) < cnt_q) begin
      mac_b = buf_rdata;
    end else begin
      mac_b = '0;
    end
    mac_acc = ws_ph_q ? ws_rdata : gr_rdata;
  end

  // memory port control
  always_comb begin
    buf_we    = s_xfer && (in_op == OP_PUSH) && (cnt_q < CntW'(LATENT_DIM));
    buf_waddr = BufAw'(cnt_q);
    buf_re    = (state_q == ST_ROW) || ((state_q == ST_RD) && !ws_ph_q);
    buf_raddr = (state_q == ST_ROW) ? i_q : j_q;

    ws_we    = 1'b0;
    ws_waddr = i_q;
    ws_wdata = mac_res.sum;
    ws_re    = ((state_q == ST_RD) && ws_ph_q) || (state_q == ST_RADDR);
    ws_raddr = (state_q == ST_RADDR) ? BufAw'(rd_r) : i_q;

    gr_we    = 1'b0;
    gr_wdata = mac_res.sum;
    gr_re    = ((state_q == ST_RD) && !ws_ph_q) || (state_q == ST_RADDR);
    gr_raddr = (state_q == ST_RADDR) ? GramAw'(rd_gidx) : gaddr_q;

    if (state_q == ST_CLR) begin
      gr_we    = 1'b1;
      gr_wdata = '0;
      ws_we    = (32'(gaddr_q) < 32'(LATENT_DIM));
      ws_waddr = BufAw'(gaddr_q);
      ws_wdata = '0;
    end else if (state_q == ST_WR) begin
      ws_we = ws_ph_q;
      gr_we = !ws_ph_q;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    gaddr_d = gaddr_q;
    cnt_d   = cnt_q;
    ws_ph_d = ws_ph_q;
    ovf_d   = ovf_q;
    vi_d    = vi_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          case (in_op)
            OP_CLEAR: begin
              cnt_d   = '0;
              ovf_d   = 1'b0;
              gaddr_d = '0;
              state_d = ST_CLR;
            end
            OP_PUSH: begin
              if (buf_we) begin
                cnt_d = cnt_q + CntW'(1);
              end
              if (s_axis_tlast_i) begin
                i_d     = '0;
                gaddr_d = '0;
                state_d = ST_ROW;
              end
            end
            OP_READ: begin
              state_d = ST_RADDR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLR: begin
        gaddr_d = gaddr_q + GramAw'(1);
        if (gaddr_q == GramAw'(GramDepth - 1)) begin
          gaddr_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_ROW: begin
        state_d = ST_VI;
      end
      ST_VI: begin
        vi_d    = (CntW'(i_q) < cnt_q) ? buf_rdata : '0;
        ws_ph_d = 1'b1;
        j_d     = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        ovf_d   = ovf_q | mac_res.sat;
        state_d = ST_RD;
        if (ws_ph_q) begin
          ws_ph_d = 1'b0;
        end else begin
          gaddr_d = gaddr_q + GramAw'(1);
          if (acc_done) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else if (row_done) begin
            i_d     = i_q + BufAw'(1);
            state_d = ST_ROW;
          end else begin
            j_d = j_q + BufAw'(1);
          end
        end
      end
      ST_RADDR: begin
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers, reset starts a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      i_q       <= '0;
      j_q       <= '0;
      gaddr_q   <= '0;
      cnt_q     <= '0;
      ws_ph_q   <= 1'b0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      gaddr_q <= gaddr_d;
      cnt_q   <= cnt_d;
      ws_ph_q <= ws_ph_d;
      ovf_q   <= ovf_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    vi_q <= vi_d;
    if (s_xfer) begin
      rating_q <= in_rating;
      rd_row_q <= in_row;
      rd_col_q <= in_col;
      rd_vec_q <= in_vec;
    end
    if (state_q == ST_RADDR) begin
      rd_zero_q <= !rd_in_range;
    end
    if (out_load) begin
      m_user_q <= ovf_q;
      if (rd_zero_q) begin
        m_data_q <= '0;
      end else begin
        m_data_q <= rd_vec_q ? ws_rdata : gr_rdata;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // vector buffer
  gawsa_ram #(
    .Width(ElemW),
    .Depth(LATENT_DIM)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (buf_we),
    .waddr_i(buf_waddr),
    .wdata_i(in_elem),
    .re_i   (buf_re),
    .raddr_i(buf_raddr),
    .rdata_o(buf_rdata)
  );

  // weighted-sum accumulators
  gawsa_ram #(
    .Width(AccW),
    .Depth(LATENT_DIM)
  ) u_ws (
    .clk_i  (clk_i),
    .we_i   (ws_we),
    .waddr_i(ws_waddr),
    .wdata_i(ws_wdata),
    .re_i   (ws_re),
    .raddr_i(ws_raddr),
    .rdata_o(ws_rdata)
  );

  // lower-triangle Gram accumulators
  gawsa_ram #(
    .Width(AccW),
    .Depth(GramDepth)
  ) u_gram (
    .clk_i  (clk_i),
    .we_i   (gr_we),
    .waddr_i(gaddr_q),
    .wdata_i(gr_wdata),
    .re_i   (gr_re),
    .raddr_i(gr_raddr),
    .rdata_o(gr_rdata)
  );

  // shared multiply-accumulate unit
  gawsa_mac u_mac (
    .clk_i   (clk_i),
    .mul_en_i(state_q == ST_MUL),
    .a_i     (vi_q),
    .b_i     (mac_b),
    .acc_i   (mac_acc),
    .res_o   (mac_res)
  );

  // fill count never passes the vector length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(LATENT_DIM))
    else $error("fill count above vector length");

  // the last Gram write of an accumulation lands on the last entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR && !ws_ph_q && acc_done) |-> gaddr_q == GramAw'(GramDepth - 1))
    else $error("gram address out of step with row/column counters");

  // a clear drops the sticky overflow flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && in_op == OP_CLEAR) |=> !ovf_q)
    else $error("overflow flag survived a clear");

  // a finished accumulation leaves an empty buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR && !ws_ph_q && acc_done) |=> (cnt_q == '0 && state_q == ST_IDLE))
    else $error("buffer not released after accumulation");

endmodule

`default_nettype wire
